FILE: design/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the line position PD steering block.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int NUM_LANES   = 6;
    localparam int READ_W      = 10;
    localparam int STATE_W     = 2;
    localparam int OFFSET_W    = 11;
    localparam int MOMENT_W    = 20;
    localparam int NUM_W       = 21;
    localparam int DEN_W       = 13;
    localparam int POS_W       = 11;
    localparam int DIFF_W      = 12;
    localparam int GAIN_W      = 8;
    localparam int LIMIT_W     = 10;
    localparam int DRIVE_W     = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int DIV_STEPS   = NUM_W - 1;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 24;

    localparam logic signed [OFFSET_W-1:0] SENSOR_OFFSET [NUM_LANES] = '{
        -11'sd500, -11'sd270, -11'sd80, 11'sd80, 11'sd270, 11'sd500
    };

    localparam logic [STATE_W-1:0] ST_BLACK = 2'b01;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 8'd3;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 8'd5;
    localparam logic [LIMIT_W-1:0] RST_LOST_THR   = 10'd450;
    localparam logic [LIMIT_W-1:0] RST_FULL_TURN  = 10'd1000;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 21'sd1048575;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -21'sd1048576;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_DERIV_GAIN = 2'd1,
        REG_LOST_THR   = 2'd2,
        REG_FULL_TURN  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                       seen;
        logic                       black;
        logic [READ_W-1:0]          weight;
        logic signed [MOMENT_W-1:0] moment;
    } t_lane_res;

endpackage

FILE: design/line_position_pd_steering.sv
// ----------------------------------------------------------------------------
// line_position_pd_steering
// PD steering from six reflectance sensors: weighted line position, lost-line
// full turn, finish stop on all black, and a saturated PD drive value.
//
//   Channel   Direction  Transaction
//   i_s_*     in         one sensor frame (readings and line states)
//   o_m_*     out        one steering result per frame
//   i_cfg_*   in         register write, no handshake
//
// A frame passes the merge, start, divide, position, multiply and sum states
// on its way to the result register; the 20-step restoring divider forms the weighted mean.
// One frame is in flight at a time; a new frame is accepted while the previous
// result still waits in the output register.
// A stalled output holds the finished frame in its last step until taken.
// Reset restores the register defaults and clears the previous position.
// ----------------------------------------------------------------------------
module line_position_pd_steering (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // reading_0..reading_5 (10 bits each), then state_0..state_5 (2 bits each)
    input  logic [lps_pkg::IN_DATA_W-1:0]        i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // steer_drive (21 bits), finish_stop (1 bit), two zero bits
    output logic [lps_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    input  logic                                 i_cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE,
        S_START,
        S_DIV,
        S_POS,
        S_MUL,
        S_SUM
    } t_state;

    t_state                     r_state;
    logic [GAIN_W-1:0]          r_prop;
    logic [GAIN_W-1:0]          r_deriv;
    logic [LIMIT_W-1:0]         r_lost_thr;
    logic [LIMIT_W-1:0]         r_full_turn;
    logic signed [POS_W-1:0]    r_prev;
    logic signed [POS_W-1:0]    r_pos;
    logic signed [DIFF_W-1:0]   r_diff;
    logic                       r_black;
    logic signed [19:0]         r_p_term;
    logic signed [DRIVE_W-1:0]  r_d_term;
    logic                       r_out_valid;
    logic signed [DRIVE_W-1:0]  r_drive;
    logic                       r_stop;

    logic                       w_accept;
    logic                       w_out_free;
    t_lane_res                  w_lane [NUM_LANES];
    logic signed [NUM_W-1:0]    w_num;
    logic [DEN_W-1:0]           w_den;
    logic                       w_all_black;
    logic                       w_any_seen;
    logic [DIV_STEPS-1:0]       w_num_mag;
    logic                       w_div_done;
    logic signed [POS_W-1:0]    w_quotient;
    logic signed [DIFF_W-1:0]   w_prev_x;
    logic signed [DIFF_W-1:0]   w_thr;
    logic signed [POS_W-1:0]    w_full;
    logic signed [POS_W-1:0]    n_pos;
    logic signed [DIFF_W-1:0]   n_diff;
    logic signed [DRIVE_W:0]    w_sum;
    logic signed [DRIVE_W-1:0]  n_drive;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lps_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_accept),
            .i_reading (i_s_tdata[g*READ_W +: READ_W]),
            .i_state   (i_s_tdata[NUM_LANES*READ_W + g*STATE_W +: STATE_W]),
            .i_offset  (SENSOR_OFFSET[g]),
            .o_res     (w_lane[g])
        );
    end

    lps_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (r_state == S_MERGE),
        .i_lane      (w_lane),
        .o_num       (w_num),
        .o_den       (w_den),
        .o_all_black (w_all_black),
        .o_any_seen  (w_any_seen)
    );

    assign w_num_mag = w_num[NUM_W-1] ? DIV_STEPS'(-w_num) : DIV_STEPS'(w_num);

    lps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (w_num_mag),
        .i_divisor  (w_den),
        .i_neg      (w_num[NUM_W-1]),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        w_prev_x = DIFF_W'(r_prev);
        w_thr    = $signed({2'b00, r_lost_thr});
        w_full   = $signed({1'b0, r_full_turn});
        n_pos    = '0;
        n_diff   = '0;
        if (w_all_black) begin
            n_pos = '0;
        end else if (w_any_seen) begin
            n_pos  = (w_den != '0) ? w_quotient : '0;
            n_diff = DIFF_W'(n_pos) - w_prev_x;
        end else if (w_prev_x < -w_thr) begin
            n_pos = -w_full;
        end else if (w_prev_x > w_thr) begin
            n_pos = w_full;
        end
        w_sum = (DRIVE_W+1)'(r_p_term) + (DRIVE_W+1)'(r_d_term);
        if (w_sum > (DRIVE_W+1)'(DRIVE_MAX)) begin
            n_drive = DRIVE_MAX;
        end else if (w_sum < (DRIVE_W+1)'(DRIVE_MIN)) begin
            n_drive = DRIVE_MIN;
        end else begin
            n_drive = w_sum[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prop      <= RST_PROP_GAIN;
            r_deriv     <= RST_DERIV_GAIN;
            r_lost_thr  <= RST_LOST_THR;
            r_full_turn <= RST_FULL_TURN;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_PROP_GAIN:  r_prop      <= i_cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN: r_deriv     <= i_cfg_data[GAIN_W-1:0];
                    REG_LOST_THR:   r_lost_thr  <= i_cfg_data;
                    REG_FULL_TURN:  r_full_turn <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_tready && r_state != S_SUM) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_pos   <= n_pos;
                    r_diff  <= n_diff;
                    r_black <= w_all_black;
                    r_prev  <= n_pos;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p_term <= 20'($signed({1'b0, r_prop}) * r_pos);
                    r_d_term <= DRIVE_W'($signed({1'b0, r_deriv}) * r_diff);
                    r_state  <= S_SUM;
                end
                S_SUM: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_drive     <= r_black ? '0 : n_drive;
                        r_stop      <= r_black;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_stop, r_drive};

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[DRIVE_W] |-> o_m_tdata[DRIVE_W-1:0] == '0)
        else $error("finish stop with nonzero drive");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_MERGE)
        else $error("accepted frame did not advance to merge");

    a_black_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POS && w_all_black |=> r_prev == '0)
        else $error("all-black frame did not clear previous position");

endmodule

FILE: design/lps_lane.sv
// ----------------------------------------------------------------------------
// lps_lane
// One sensor lane: classifies the state and forms the weighted moment.
// ----------------------------------------------------------------------------
module lps_lane (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [lps_pkg::READ_W-1:0]            i_reading,
    input  logic [lps_pkg::STATE_W-1:0]           i_state,
    input  logic signed [lps_pkg::OFFSET_W-1:0]   i_offset,
    output lps_pkg::t_lane_res                    o_res
);
    import lps_pkg::*;

    t_lane_res r_res;
    t_lane_res n_res;

    always_comb begin
        n_res.seen   = ~i_state[STATE_W-1];
        n_res.black  = (i_state == ST_BLACK);
        n_res.weight = n_res.seen ? i_reading : '0;
        n_res.moment = n_res.seen
                       ? MOMENT_W'(i_offset * $signed({1'b0, i_reading}))
                       : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: design/lps_merge.sv
// ----------------------------------------------------------------------------
// lps_merge
// Combines the lane results into the moment sum, weight sum and line flags.
// ----------------------------------------------------------------------------
module lps_merge (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  lps_pkg::t_lane_res                  i_lane [lps_pkg::NUM_LANES],
    output logic signed [lps_pkg::NUM_W-1:0]    o_num,
    output logic [lps_pkg::DEN_W-1:0]           o_den,
    output logic                                o_all_black,
    output logic                                o_any_seen
);
    import lps_pkg::*;

    logic signed [NUM_W-1:0] r_num;
    logic signed [NUM_W-1:0] n_num;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        n_den;
    logic                    r_all_black;
    logic                    n_all_black;
    logic                    r_any_seen;
    logic                    n_any_seen;

    always_comb begin
        n_num       = '0;
        n_den       = '0;
        n_all_black = 1'b1;
        n_any_seen  = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            n_num       = n_num + NUM_W'(i_lane[i].moment);
            n_den       = n_den + DEN_W'(i_lane[i].weight);
            n_all_black = n_all_black & i_lane[i].black;
            n_any_seen  = n_any_seen | i_lane[i].seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num       <= n_num;
            r_den       <= n_den;
            r_all_black <= n_all_black;
            r_any_seen  <= n_any_seen;
        end
    end

    assign o_num       = r_num;
    assign o_den       = r_den;
    assign o_all_black = r_all_black;
    assign o_any_seen  = r_any_seen;

endmodule

FILE: design/lps_div.sv
// ----------------------------------------------------------------------------
// lps_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lps_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lps_pkg::DIV_STEPS-1:0]       i_dividend,
    input  logic [lps_pkg::DEN_W-1:0]           i_divisor,
    input  logic                                i_neg,
    output logic                                o_done,
    output logic signed [lps_pkg::POS_W-1:0]    o_quotient
);
    import lps_pkg::*;

    logic [DEN_W:0]         r_rem;
    logic [DIV_STEPS-1:0]   r_quo;
    logic [DEN_W-1:0]       r_den;
    logic                   r_neg;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [DEN_W:0]         n_shift;
    logic [DEN_W+1:0]       n_trial;

    always_comb begin
        n_shift = {r_rem[DEN_W-1:0], r_quo[DIV_STEPS-1]};
        n_trial = {1'b0, n_shift} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_neg <= i_neg;
        end else if (r_busy) begin
            if (!n_trial[DEN_W+1]) begin
                r_rem <= n_trial[DEN_W:0];
                r_quo <= {r_quo[DIV_STEPS-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo[POS_W-1:0]) : $signed(r_quo[POS_W-1:0]);

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_position_pd_steering. Sensor frames are queued
// by a stimulus process and streamed in bursts with random gaps, while the
// result side stalls on its own changing pattern. Every accepted frame is run
// through a local PD steering predictor, and every result is compared field by
// field with the oldest prediction. Register settings change between phases,
// only while the block is idle, and cover gains of 0 and 255 and limits of 0 and 1000.
// ----------------------------------------------------------------------------
module tb;
    import lps_pkg::*;

    localparam logic [STATE_W-1:0] S_SEEN  = 2'b00;
    localparam logic [STATE_W-1:0] S_WHITE = 2'b11;
    localparam logic [STATE_W-1:0] S_OFF   = 2'b10;
    localparam int LANE_POS [NUM_LANES] = '{-500, -270, -80, 80, 270, 500};

    typedef struct packed {
        logic                stop;
        logic [DRIVE_W-1:0]  steer;
    } t_steer_res;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    logic [IN_DATA_W-1:0]    frame_q [$];
    t_steer_res              steer_q [$];
    int                      err_count = 0;

    int                      kp = RST_PROP_GAIN;
    int                      kd = RST_DERIV_GAIN;
    int                      lost_thr = RST_LOST_THR;
    int                      turn_mag = RST_FULL_TURN;
    int                      last_pos = 0;

    int                      burst_left = 0;
    int                      gap_left = 0;
    logic [31:0]             ready_mask = '1;
    logic [7:0]              ready_tick = '0;

    line_position_pd_steering uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [IN_DATA_W-1:0] frame_of(input logic [5:0][9:0] rd,
                                                      input logic [5:0][1:0] st);
        return {st, rd};
    endfunction

    function automatic logic [READ_W-1:0] rand_reading();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return READ_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_frame();
        logic [5:0][9:0] rd;
        logic [5:0][1:0] st;
        int kind;
        int k;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < NUM_LANES; i++) begin
            rd[i] = rand_reading();
            k = $urandom_range(0, 19);
            if (k < 9) begin
                st[i] = S_SEEN;
            end else if (k < 15) begin
                st[i] = S_WHITE;
            end else if (k < 17) begin
                st[i] = S_OFF;
            end else begin
                st[i] = ST_BLACK;
            end
        end
        if (kind < 6) begin
            st = {NUM_LANES{ST_BLACK}};
        end else if (kind < 18) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                st[i] = ($urandom_range(0, 3) == 0) ? S_OFF : S_WHITE;
            end
        end else if (kind < 22) begin
            st = 12'($urandom);
        end else if (kind < 26) begin
            rd = '0;
        end
        return frame_of(rd, st);
    endfunction

    function automatic t_steer_res steer_predict(input logic [IN_DATA_W-1:0] d);
        logic [STATE_W-1:0] code;
        bit                 all_black;
        bit                 any_seen;
        longint             num;
        longint             den;
        longint             r;
        longint             pos;
        longint             diff;
        longint             drv;
        t_steer_res         res;
        all_black = 1'b1;
        any_seen  = 1'b0;
        num  = 0;
        den  = 0;
        pos  = 0;
        diff = 0;
        for (int i = 0; i < NUM_LANES; i++) begin
            code = d[NUM_LANES*READ_W + STATE_W*i +: STATE_W];
            if (code != ST_BLACK) all_black = 1'b0;
            if (!code[1]) any_seen = 1'b1;
        end
        if (all_black) begin
            last_pos  = 0;
            res.stop  = 1'b1;
            res.steer = '0;
            return res;
        end
        if (any_seen) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                code = d[NUM_LANES*READ_W + STATE_W*i +: STATE_W];
                if (!code[1]) begin
                    r = d[READ_W*i +: READ_W];
                    num += r * LANE_POS[i];
                    den += r;
                end
            end
            if (den != 0) pos = num / den;
            diff = pos - last_pos;
        end else if (last_pos < -lost_thr) begin
            pos = -turn_mag;
        end else if (last_pos > lost_thr) begin
            pos = turn_mag;
        end
        last_pos = int'(pos);
        drv = kp * pos + kd * diff;
        if (drv > 1048575) drv = 1048575;
        if (drv < -1048576) drv = -1048576;
        res.stop  = 1'b0;
        res.steer = drv[DRIVE_W-1:0];
        return res;
    endfunction

    task automatic report_err(input string msg);
        $display("tb: mismatch: %s", msg);
        err_count++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_PROP_GAIN:  kp = val & 255;
            REG_DERIV_GAIN: kd = val & 255;
            REG_LOST_THR:   lost_thr = val & 1023;
            REG_FULL_TURN:  turn_mag = val & 1023;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(input int p, input int dg, input int thr, input int turn);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_DERIV_GAIN, dg);
        write_reg(REG_LOST_THR, thr);
        write_reg(REG_FULL_TURN, turn);
    endtask

    task automatic wait_idle();
        while (frame_q.size() != 0 || s_tvalid || steer_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Sender: bursts of frames separated by random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                s_tdata  <= frame_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 10);
                        default:    gap_left = $urandom_range(20, 60);
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a rotating mask that is replaced whenever the 8-bit tick wraps.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (ready_tick == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_mask = '1;
                    1:       ready_mask = $urandom;
                    2:       ready_mask = 32'h0101_0101 << $urandom_range(0, 7);
                    default: ready_mask = $urandom | $urandom;
                endcase
            end
            m_tready <= ready_mask[ready_tick[4:0]];
            ready_tick++;
        end
    end

    always @(posedge clk) begin
        t_steer_res want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (steer_q.size() == 0) begin
                    report_err($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = steer_q.pop_front();
                    if (m_tdata[DRIVE_W-1:0] !== want.steer)
                        report_err($sformatf("steer_drive %0d, expected %0d",
                                             $signed(m_tdata[DRIVE_W-1:0]),
                                             $signed(want.steer)));
                    if (m_tdata[DRIVE_W] !== want.stop)
                        report_err($sformatf("finish_stop %b, expected %b",
                                             m_tdata[DRIVE_W], want.stop));
                end
            end
            if (s_tvalid && s_tready) steer_q.push_back(steer_predict(s_tdata));
        end
    end

    initial begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        logic [5:0][9:0] rd;
        logic [5:0][1:0] st;
        int              count;
        int              side;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        frame_q.push_back(frame_of('1, {NUM_LANES{ST_BLACK}}));
        rd = '0;
        rd[0] = 10'd1023;
        st = {NUM_LANES{S_WHITE}};
        st[0] = S_SEEN;
        frame_q.push_back(frame_of(rd, st));
        frame_q.push_back(frame_of('1, {NUM_LANES{S_WHITE}}));
        frame_q.push_back(frame_of('0, {NUM_LANES{S_WHITE}}));
        rd = '0;
        rd[5] = 10'd1023;
        st = {NUM_LANES{S_WHITE}};
        st[5] = S_SEEN;
        frame_q.push_back(frame_of(rd, st));
        frame_q.push_back(frame_of('1, {NUM_LANES{S_WHITE}}));
        frame_q.push_back(frame_of('1, {NUM_LANES{S_OFF}}));
        frame_q.push_back(frame_of('0, {NUM_LANES{S_SEEN}}));
        frame_q.push_back(frame_of('1, {NUM_LANES{S_SEEN}}));
        rd = '0;
        rd[2] = 10'd1;
        rd[3] = 10'd2;
        st = {S_WHITE, S_OFF, S_SEEN, S_SEEN, S_OFF, S_WHITE};
        frame_q.push_back(frame_of(rd, st));
        rd[2] = 10'd2;
        rd[3] = 10'd1;
        frame_q.push_back(frame_of(rd, st));
        frame_q.push_back(frame_of('1, {S_OFF, S_WHITE, S_OFF, S_WHITE, S_OFF, S_WHITE}));
        st = {NUM_LANES{ST_BLACK}};
        st[1] = S_SEEN;
        frame_q.push_back(frame_of('1, st));
        st = {NUM_LANES{ST_BLACK}};
        st[4] = S_WHITE;
        frame_q.push_back(frame_of('1, st));
        frame_q.push_back(frame_of('0, {NUM_LANES{ST_BLACK}}));
        frame_q.push_back(frame_of('1, {NUM_LANES{S_WHITE}}));
        rd = {10'd1023, 10'd0, 10'd512, 10'd1, 10'd1022, 10'd341};
        frame_q.push_back(frame_of(rd, {S_SEEN, ST_BLACK, S_OFF, S_SEEN, S_WHITE, S_SEEN}));
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1:       set_gains(0, 0, 0, 0);
                2:       set_gains(255, 255, 1000, 1000);
                3:       set_gains(1, 255, 0, 1000);
                4:       set_gains(255, 1, 1000, 0);
                5, 6:    set_gains($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 1000), $urandom_range(0, 1000));
                7:       set_gains(RST_PROP_GAIN, RST_DERIV_GAIN, RST_LOST_THR,
                                   RST_FULL_TURN);
                default: ;
            endcase
            count = 0;
            while (count < 200) begin
                if ($urandom_range(0, 7) == 0) begin
                    // Line seen near one edge, then lost for a few frames.
                    side = $urandom_range(0, 3);
                    rd = {6{rand_reading()}};
                    for (int i = 0; i < NUM_LANES; i++) rd[i] = rand_reading();
                    st = {NUM_LANES{S_WHITE}};
                    case (side)
                        0:       st[0] = S_SEEN;
                        1:       st[5] = S_SEEN;
                        2:       begin st[0] = S_SEEN; st[1] = S_SEEN; end
                        default: begin st[4] = S_SEEN; st[5] = S_SEEN; end
                    endcase
                    frame_q.push_back(frame_of(rd, st));
                    count++;
                    repeat ($urandom_range(1, 4)) begin
                        for (int i = 0; i < NUM_LANES; i++) begin
                            rd[i] = rand_reading();
                            st[i] = ($urandom_range(0, 3) == 0) ? S_OFF : S_WHITE;
                        end
                        frame_q.push_back(frame_of(rd, st));
                        count++;
                    end
                end else begin
                    frame_q.push_back(rand_frame());
                    count++;
                end
            end
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
